/* sv/bgs_pkg.sv */
// ---------------------------------------------------------------------------
// Bracket group splitter package
// Token kind codes, result status codes and the types passed between the
// front end, the stack engine and the queues.
// ---------------------------------------------------------------------------
package bgs_pkg;

  // Default number of open brackets the stack can hold.
  localparam int STACK_DEPTH_DEF = 64;

  // Queue depths between the front end and the stack engine, and at the output.
  localparam int FRONT_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH   = 2;

  // Token kind codes as they arrive from the lexer.
  localparam logic [2:0] KIND_PLAIN   = 3'd0;
  localparam logic [2:0] KIND_PAREN_O = 3'd1;
  localparam logic [2:0] KIND_PAREN_C = 3'd2;
  localparam logic [2:0] KIND_SQR_O   = 3'd3;
  localparam logic [2:0] KIND_SQR_C   = 3'd4;
  localparam logic [2:0] KIND_CURL_O  = 3'd5;
  localparam logic [2:0] KIND_CURL_C  = 3'd6;
  localparam logic [2:0] KIND_COMMA   = 3'd7;

  // Bracket type codes kept on the stack.
  localparam logic [1:0] BR_PAREN = 2'd0;
  localparam logic [1:0] BR_SQR   = 2'd1;
  localparam logic [1:0] BR_CURL  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_OPEN   = 3'd1;
  localparam logic [2:0] ST_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_UNCLOSED  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;
  localparam logic [2:0] ST_FAILED    = 3'd5;

  // A token after classification by the front end.
  typedef struct packed {
    logic [15:0] pos;
    logic        is_open;
    logic        is_close;
    logic        is_sep;
    logic [1:0]  btype;
    logic        last;
  } cls_t;

  // One result request.
  typedef struct packed {
    logic [15:0] echo_position;
    logic        group_closed;
    logic        separator;
    logic [6:0]  nesting;
    logic [2:0]  status;
    logic [15:0] culprit_position;
    logic        phrase_done;
  } res_t;

endpackage

/* sv/bgs_fifo.sv */
// ---------------------------------------------------------------------------
// Bracket group splitter queue
// Small synchronous FIFO built from registers, used between the stages.
// ---------------------------------------------------------------------------
module bgs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  // Status flags and head of the queue.
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign dout    = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and count updates, with explicit wrap for any depth.
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= din;
    end
  end

endmodule

/* sv/bgs_front.sv */
// ---------------------------------------------------------------------------
// Bracket group splitter front end
// Accepts tokens, decodes the kind code and queues them for the stack engine.
// ---------------------------------------------------------------------------
module bgs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [15:0]      in_token_position,
  input  logic [2:0]       in_token_kind,
  input  logic             in_phrase_end,
  output bgs_pkg::cls_t    q_head,
  output logic             q_empty,
  input  logic             q_pop
);

  import bgs_pkg::*;

  cls_t                cls;
  logic [$bits(cls_t)-1:0] q_dout;

  // Decode the kind code into open, close or comma and a bracket type.
  always_comb begin
    cls          = '0;
    cls.pos      = in_token_position;
    cls.last     = in_phrase_end;
    case (in_token_kind)
      KIND_PAREN_O: begin
        cls.is_open = 1'b1;
        cls.btype   = BR_PAREN;
      end
      KIND_SQR_O: begin
        cls.is_open = 1'b1;
        cls.btype   = BR_SQR;
      end
      KIND_CURL_O: begin
        cls.is_open = 1'b1;
        cls.btype   = BR_CURL;
      end
      KIND_PAREN_C: begin
        cls.is_close = 1'b1;
        cls.btype    = BR_PAREN;
      end
      KIND_SQR_C: begin
        cls.is_close = 1'b1;
        cls.btype    = BR_SQR;
      end
      KIND_CURL_C: begin
        cls.is_close = 1'b1;
        cls.btype    = BR_CURL;
      end
      KIND_COMMA: begin
        cls.is_sep = 1'b1;
      end
      KIND_PLAIN: begin
        cls.btype = BR_PAREN;
      end
      default: begin
        cls.btype = BR_PAREN;
      end
    endcase
  end

  // Decoupling queue toward the stack engine.
  bgs_fifo #(
    .W     ($bits(cls_t)),
    .DEPTH (FRONT_Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cls),
    .full  (in_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign q_head = cls_t'(q_dout);

endmodule

/* sv/bgs_back.sv */
// ---------------------------------------------------------------------------
// Bracket group splitter stack engine
// Keeps the open bracket stack, checks each token against the stack top and
// queues one result per token.
// ---------------------------------------------------------------------------
module bgs_back #(
  parameter int STACK_DEPTH = bgs_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bgs_pkg::cls_t    q_head,
  input  logic             q_empty,
  output logic             q_pop,
  output bgs_pkg::res_t    res,
  output logic             res_empty,
  input  logic             res_pop
);

  import bgs_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pos;
  } ent_t;

  // Stack storage; each read is registered in the cycle before its use.
  ent_t mem [STACK_DEPTH];

  logic [LW-1:0]   level_r, level_nxt;
  logic            failed_r, failed_nxt;
  logic            byp_r;
  ent_t            wr_ent_r;
  ent_t            rda_r, rdb_r;

  ent_t            top, second, new_ent;
  logic            fire, oq_full;
  logic            op_push, op_pop;
  logic [2:0]      status;
  logic [15:0]     culprit;
  logic [LW-1:0]   level_after;
  logic [LW-1:0]   lvl_m1, lvl_m2;
  logic [LW+6:0]   lvl_ext;
  logic [6:0]      nest;
  logic            ok, fail_set;
  res_t            res_in;
  logic [$bits(res_t)-1:0] oq_dout;

  // Process the queue head whenever the result queue has room.
  assign fire  = !q_empty && !oq_full;
  assign q_pop = fire;

  // Stack top comes from the last push directly, else from the read port.
  assign top         = byp_r ? wr_ent_r : rda_r;
  assign second      = rdb_r;
  assign new_ent.kind = q_head.btype;
  assign new_ent.pos  = q_head.pos;

  // Token checks against the stack.
  always_comb begin
    op_push = 1'b0;
    op_pop  = 1'b0;
    status  = ST_OK;
    culprit = '0;
    if (failed_r) begin
      status = ST_FAILED;
    end else if (q_head.is_open) begin
      if (level_r == LW'(STACK_DEPTH)) begin
        status = ST_OVERFLOW;
      end else begin
        op_push = 1'b1;
      end
    end else if (q_head.is_close) begin
      if (level_r == '0) begin
        status = ST_NO_OPEN;
      end else if (top.kind != q_head.btype) begin
        status  = ST_MISMATCH;
        culprit = top.pos;
      end else begin
        op_pop = 1'b1;
      end
    end

    if (op_push) begin
      level_after = level_r + LW'(1);
    end else if (op_pop) begin
      level_after = level_r - LW'(1);
    end else begin
      level_after = level_r;
    end

    // Innermost opener still pending at the end of the phrase.
    if (status == ST_OK && q_head.last && level_after != '0) begin
      status = ST_UNCLOSED;
      if (op_push) begin
        culprit = q_head.pos;
      end else if (op_pop) begin
        culprit = second.pos;
      end else begin
        culprit = top.pos;
      end
    end
  end

  assign ok       = (status == ST_OK);
  assign fail_set = !ok && (status != ST_FAILED);

  // Depth reported on the result saturates at 127.
  assign lvl_ext = {7'b0, level_after};
  assign nest    = (lvl_ext > (LW + 7)'(127)) ? 7'd127 : lvl_ext[6:0];

  always_comb begin
    res_in.echo_position    = q_head.pos;
    res_in.group_closed     = ok && (level_after == '0);
    res_in.separator        = ok && q_head.is_sep && (level_after == '0);
    res_in.nesting          = nest;
    res_in.status           = status;
    res_in.culprit_position = culprit;
    res_in.phrase_done      = q_head.last;
  end

  // Level and failed mark; the last token of a phrase clears both.
  always_comb begin
    level_nxt  = level_r;
    failed_nxt = failed_r;
    if (fire) begin
      if (q_head.last) begin
        level_nxt  = '0;
        failed_nxt = 1'b0;
      end else begin
        level_nxt  = level_after;
        failed_nxt = failed_r | fail_set;
      end
    end
  end

  assign lvl_m1 = level_nxt - LW'(1);
  assign lvl_m2 = level_nxt - LW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      failed_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      level_r  <= level_nxt;
      failed_r <= failed_nxt;
      byp_r    <= fire && op_push;
    end
  end

  // Stack memory: one write, two registered reads for top and next entry.
  always_ff @(posedge clk) begin
    if (fire && op_push) begin
      mem[level_r[AW-1:0]] <= new_ent;
      wr_ent_r             <= new_ent;
    end
    rda_r <= mem[lvl_m1[AW-1:0]];
    rdb_r <= mem[lvl_m2[AW-1:0]];
  end

  // Output queue decouples the engine from the consumer.
  bgs_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fire),
    .din   (res_in),
    .full  (oq_full),
    .pop   (res_pop),
    .dout  (oq_dout),
    .empty (res_empty)
  );

  assign res = res_t'(oq_dout);

  // The stack level never exceeds the configured depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(STACK_DEPTH))
    else $error("stack level above depth");

  // The last token of a phrase leaves an empty stack and a clean phrase.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && q_head.last |=> level_r == '0 && !failed_r)
    else $error("phrase end did not clear the stack");

  // A successful open inside a phrase grows the stack by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && op_push && !q_head.last |=> level_r == $past(level_r) + LW'(1))
    else $error("push did not grow the stack");

  // An unclosed report is only ever given on the last token.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && status == ST_UNCLOSED |-> q_head.last)
    else $error("unclosed status before phrase end");

  // A failed phrase leaves the stack level unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && failed_r && !q_head.last |=> level_r == $past(level_r))
    else $error("failed phrase changed the stack");

endmodule

/* sv/bracket_group_splitter.sv */
// A token accepted into the front queue moves to the stack engine when the output
// queue has room; its result is registered in the output queue and popped from there.
// Throughput: one token per cycle while the output queue has room, set by the single
// stack top compare and push or pop in the stack engine each cycle.
// Reset (rst_n low, synchronous) empties both queues, the stack level and the
// failed mark; stack memory contents are not cleared and need no clearing.
// ---------------------------------------------------------------------------
// Bracket group splitter
// Splits a token phrase into top-level groups, tracking bracket nesting.
// ---------------------------------------------------------------------------
module bracket_group_splitter #(
  parameter int STACK_DEPTH = bgs_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_token_position,
  input  logic [2:0]  in_token_kind,
  input  logic        in_phrase_end,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_echo_position,
  output logic        out_group_closed,
  output logic        out_separator,
  output logic [6:0]  out_nesting,
  output logic [2:0]  out_status,
  output logic [15:0] out_culprit_position,
  output logic        out_phrase_done
);

  import bgs_pkg::*;

  cls_t q_head;
  logic q_empty, q_pop;
  res_t res;

  // Token intake and classification.
  bgs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_token_position (in_token_position),
    .in_token_kind     (in_token_kind),
    .in_phrase_end     (in_phrase_end),
    .q_head            (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop)
  );

  // Bracket stack and result generation.
  bgs_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .res_empty (out_empty),
    .res_pop   (out_pop)
  );

  assign out_echo_position    = res.echo_position;
  assign out_group_closed     = res.group_closed;
  assign out_separator        = res.separator;
  assign out_nesting          = res.nesting;
  assign out_status           = res.status;
  assign out_culprit_position = res.culprit_position;
  assign out_phrase_done      = res.phrase_done;

endmodule

/* bench/tb_bracket_group_splitter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bracket group splitter testbench
// Streams token phrases into the splitter through its push/full queue and
// drains results through empty/pop, with random idle gaps on both sides.
// A scoreboard tracks the open-bracket stack itself and checks every result
// field in order: balanced phrases, broken ones, deep nesting up to and past
// the stack capacity, and random token noise.
// ---------------------------------------------------------------------------
module tb_bracket_group_splitter;
  import bgs_pkg::*;

  localparam int DEPTH       = STACK_DEPTH_DEF;
  localparam int TOKEN_GOAL  = 1900;
  localparam int IDLE_LIMIT  = 1000;

  // Tracks the bracket stack of the current phrase and holds the results
  // still owed by the block, oldest first.
  class bracket_tracker;
    logic [1:0]  open_type [DEPTH];
    logic [15:0] open_pos [DEPTH];
    int          level;
    bit          failed;
    res_t        owed [$];
    int          mismatches;

    function logic [1:0] bracket_of(logic [2:0] kind);
      case (kind)
        KIND_PAREN_O, KIND_PAREN_C: return BR_PAREN;
        KIND_SQR_O, KIND_SQR_C:     return BR_SQR;
        default:                    return BR_CURL;
      endcase
    endfunction

    // Work out the result of one accepted token and queue it.
    function void note_token(logic [15:0] pos, logic [2:0] kind, logic last);
      res_t        r;
      logic [2:0]  st;
      logic [15:0] culprit;
      st = ST_OK;
      culprit = '0;
      if (failed) begin
        st = ST_FAILED;
      end else if (kind == KIND_PAREN_O || kind == KIND_SQR_O || kind == KIND_CURL_O) begin
        if (level >= DEPTH) begin
          st = ST_OVERFLOW;
        end else begin
          open_type[level] = bracket_of(kind);
          open_pos[level] = pos;
          level++;
        end
      end else if (kind == KIND_PAREN_C || kind == KIND_SQR_C || kind == KIND_CURL_C) begin
        if (level == 0) begin
          st = ST_NO_OPEN;
        end else if (open_type[level-1] != bracket_of(kind)) begin
          st = ST_MISMATCH;
          culprit = open_pos[level-1];
        end else begin
          level--;
        end
      end
      // A phrase may not end with brackets still open.
      if (st == ST_OK && last && level > 0) begin
        st = ST_UNCLOSED;
        culprit = open_pos[level-1];
      end
      r.echo_position = pos;
      r.group_closed = (st == ST_OK && level == 0);
      r.separator = (st == ST_OK && kind == KIND_COMMA && level == 0);
      r.nesting = 7'(level);
      r.status = st;
      r.culprit_position = culprit;
      r.phrase_done = last;
      owed.insert(owed.size(), r);
      if (st != ST_OK && st != ST_FAILED) failed = 1'b1;
      if (last) begin
        level = 0;
        failed = 1'b0;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one result taken from the block against the oldest one owed.
    function void check_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        $error("result at position %0d arrived with none outstanding", got.echo_position);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      compare_field("echo_position", want.echo_position, got.echo_position);
      compare_field("group_closed", want.group_closed, got.group_closed);
      compare_field("separator", want.separator, got.separator);
      compare_field("nesting", want.nesting, got.nesting);
      compare_field("status", want.status, got.status);
      compare_field("culprit_position", want.culprit_position, got.culprit_position);
      compare_field("phrase_done", want.phrase_done, got.phrase_done);
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [15:0] in_token_position;
  logic [2:0]  in_token_kind;
  logic        in_phrase_end;
  logic        out_empty;
  logic        out_pop;
  logic [15:0] out_echo_position;
  logic        out_group_closed;
  logic        out_separator;
  logic [6:0]  out_nesting;
  logic [2:0]  out_status;
  logic [15:0] out_culprit_position;
  logic        out_phrase_done;

  bracket_tracker tracker = new;
  bit             quiet;
  int             stall_left;
  int             idle_cycles;
  int             tokens_sent;
  logic [2:0]     phrase_kinds [$];

  bracket_group_splitter #(.STACK_DEPTH(DEPTH)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_token_position    (in_token_position),
    .in_token_kind        (in_token_kind),
    .in_phrase_end        (in_phrase_end),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_echo_position    (out_echo_position),
    .out_group_closed     (out_group_closed),
    .out_separator        (out_separator),
    .out_nesting          (out_nesting),
    .out_status           (out_status),
    .out_culprit_position (out_culprit_position),
    .out_phrase_done      (out_phrase_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long; none in quiet stretches.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result side: random pop stalls, and every popped result goes to the tracker.
  always @(posedge clk) begin
    res_t got;
    int   n;
    if (!rst_n) begin
      out_pop <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        got.echo_position = out_echo_position;
        got.group_closed = out_group_closed;
        got.separator = out_separator;
        got.nesting = out_nesting;
        got.status = out_status;
        got.culprit_position = out_culprit_position;
        got.phrase_done = out_phrase_done;
        tracker.check_result(got);
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_pop <= 1'b0;
          stall_left <= n - 1;
        end else begin
          out_pop <= 1'b1;
        end
      end
    end
  end

  // Watchdog: ends the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_bracket_group_splitter: FAIL");
        $finish;
      end
    end
  end

  // Push one token, after an optional gap, and hold it until it is accepted.
  task automatic send_token(input logic [15:0] pos, input logic [2:0] kind, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_token_position <= pos;
    in_token_kind <= kind;
    in_phrase_end <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    tracker.note_token(pos, kind, last);
    tokens_sent++;
  endtask

  // Send the built phrase with random positions, marking its final token.
  task automatic send_phrase();
    for (int i = 0; i < phrase_kinds.size(); i++) begin
      send_token(16'($urandom_range(0, 65535)), phrase_kinds[i], i == phrase_kinds.size() - 1);
    end
  endtask

  function automatic logic [2:0] opener_kind(int t);
    case (t)
      0:       return KIND_PAREN_O;
      1:       return KIND_SQR_O;
      default: return KIND_CURL_O;
    endcase
  endfunction

  function automatic logic [2:0] closer_kind(int t);
    case (t)
      0:       return KIND_PAREN_C;
      1:       return KIND_SQR_C;
      default: return KIND_CURL_C;
    endcase
  endfunction

  // Build a balanced phrase: random opens, matching closes, plain tokens, commas.
  function automatic void build_balanced(int len);
    int open_types [$];
    int r;
    int t;
    phrase_kinds.delete();
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (open_types.size() > 0 && r < 35) begin
        t = open_types[open_types.size() - 1];
        open_types.delete(open_types.size() - 1);
        phrase_kinds.insert(phrase_kinds.size(), closer_kind(t));
      end else if (r < 60) begin
        t = $urandom_range(0, 2);
        open_types.insert(open_types.size(), t);
        phrase_kinds.insert(phrase_kinds.size(), opener_kind(t));
      end else if (r < 80) begin
        phrase_kinds.insert(phrase_kinds.size(), KIND_PLAIN);
      end else begin
        phrase_kinds.insert(phrase_kinds.size(), KIND_COMMA);
      end
    end
    while (open_types.size() > 0) begin
      t = open_types[open_types.size() - 1];
      open_types.delete(open_types.size() - 1);
      phrase_kinds.insert(phrase_kinds.size(), closer_kind(t));
    end
  endfunction

  // Build a phrase that nests close to, at, or past the stack capacity.
  function automatic void build_deep();
    int open_types [$];
    int d;
    int t;
    phrase_kinds.delete();
    d = $urandom_range(DEPTH - 8, DEPTH + 6);
    for (int i = 0; i < d; i++) begin
      t = $urandom_range(0, 2);
      open_types.insert(open_types.size(), t);
      phrase_kinds.insert(phrase_kinds.size(), opener_kind(t));
      if ($urandom_range(0, 9) == 0) phrase_kinds.insert(phrase_kinds.size(), KIND_COMMA);
    end
    while (open_types.size() > 0) begin
      t = open_types[open_types.size() - 1];
      open_types.delete(open_types.size() - 1);
      phrase_kinds.insert(phrase_kinds.size(), closer_kind(t));
    end
  endfunction

  // Damage a balanced phrase: change, drop or add one token.
  function automatic void mutate_phrase();
    int idx;
    int r;
    idx = $urandom_range(0, phrase_kinds.size() - 1);
    r = $urandom_range(0, 2);
    if (r == 0) begin
      phrase_kinds[idx] = 3'($urandom_range(0, 7));
    end else if (r == 1 && phrase_kinds.size() > 1) begin
      phrase_kinds.delete(idx);
    end else begin
      phrase_kinds.insert(idx, closer_kind($urandom_range(0, 2)));
    end
  endfunction

  function automatic void build_noise(int len);
    phrase_kinds.delete();
    for (int i = 0; i < len; i++) begin
      phrase_kinds.insert(phrase_kinds.size(), 3'($urandom_range(0, 7)));
    end
  endfunction

  initial begin
    int r;
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_token_position <= '0;
    in_token_kind <= KIND_PLAIN;
    in_phrase_end <= 1'b0;
    quiet = 1'b0;
    tokens_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a clean phrase with every kind, nested groups and commas at
    // top level and inside brackets.
    send_token(16'h0000, KIND_PLAIN, 1'b0);
    send_token(16'hFFFF, KIND_COMMA, 1'b0);
    send_token(16'h1234, KIND_PAREN_O, 1'b0);
    send_token(16'h5555, KIND_SQR_O, 1'b0);
    send_token(16'hAAAA, KIND_CURL_O, 1'b0);
    send_token(16'h0001, KIND_COMMA, 1'b0);
    send_token(16'h8000, KIND_CURL_C, 1'b0);
    send_token(16'h7FFF, KIND_SQR_C, 1'b0);
    send_token(16'h00FF, KIND_PAREN_C, 1'b0);
    send_token(16'hFF00, KIND_PLAIN, 1'b1);
    // A close with nothing open on the last token.
    send_token(16'h0F0F, KIND_PAREN_C, 1'b1);
    // A mismatched close, then tokens of the already failed phrase.
    send_token(16'hBEEF, KIND_PAREN_O, 1'b0);
    send_token(16'h0002, KIND_SQR_C, 1'b0);
    send_token(16'h0003, KIND_PLAIN, 1'b0);
    send_token(16'h0004, KIND_COMMA, 1'b1);
    // Brackets left open at the end of the phrase.
    send_token(16'hC0DE, KIND_CURL_O, 1'b0);
    send_token(16'hFACE, KIND_SQR_O, 1'b1);
    send_token(16'hFFFE, KIND_PAREN_O, 1'b1);
    // A stray close fails the phrase even though later brackets balance.
    send_token(16'h0010, KIND_CURL_C, 1'b0);
    send_token(16'h0020, KIND_CURL_O, 1'b0);
    send_token(16'h0030, KIND_CURL_C, 1'b1);

    // Let the block drain completely before the random part.
    in_push <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);

    // Random phrases: mostly balanced, some damaged, some deep, some noise.
    while (tokens_sent < TOKEN_GOAL) begin
      quiet = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        build_balanced($urandom_range(1, 24));
      end else if (r < 80) begin
        build_balanced($urandom_range(1, 24));
        mutate_phrase();
      end else if (r < 88) begin
        build_deep();
      end else begin
        build_noise($urandom_range(1, 12));
      end
      send_phrase();
    end
    quiet = 1'b0;
    in_push <= 1'b0;

    // Wait for every result, then a little longer for anything unexpected.
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb_bracket_group_splitter: PASS");
    end else begin
      $display("tb_bracket_group_splitter: FAIL");
    end
    $finish;
  end

endmodule
